[design/bc1_bc2_bc3_block_decoder_defines.svh]
// ----------------------------------------------------------------------------
// bc1_bc2_bc3_block_decoder_defines
// assertion macros used by the checker file of the block decoder
// ----------------------------------------------------------------------------
`ifndef BC1_BC2_BC3_BLOCK_DECODER_DEFINES_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during rst
`define BCDEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define BCDEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/bcdec_pkg.sv]
// ----------------------------------------------------------------------------
// bcdec_pkg
// types, constants and palette and alpha ramp helpers of the bc1/bc2/bc3 block decoder
// ----------------------------------------------------------------------------
package bcdec_pkg;

  localparam int MAX_SIDE    = 4096;
  localparam int SIDE_W      = 13;
  localparam int COORD_W     = 12;
  localparam int BLK_W       = 10;
  localparam int BCOUNT_W    = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] FMT_BC1_RGB  = 2'd0;
  localparam logic [1:0] FMT_BC1_RGBA = 2'd1;
  localparam logic [1:0] FMT_BC2      = 2'd2;
  localparam logic [1:0] FMT_BC3      = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    logic [63:0] alpha_half;
    logic [63:0] colour_half;
  } block_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic               last_of_block;
    logic               last_of_image;
  } texel_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [SIDE_W-1:0]    data;
  } cfg_wr_t;

  typedef struct packed {
    logic [3:0][2:0][7:0] rgb;
    logic                 clear3;
  } palette_t;

  typedef struct packed {
    palette_t           pal;
    logic [7:0][7:0]    ramp;
    logic [63:0]        alpha_bits;
    logic [31:0]        sel;
    logic [1:0]         fmt;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [1:0]         last_px;
    logic [1:0]         last_py;
    logic               last_block;
  } block_entry_t;

  // truncating divides by reciprocal multiply, exact over the ranges used
  function automatic logic [7:0] div3(input logic [9:0] v);
    logic [25:0] p;
    p = {16'b0, v} * 26'd21846;
    return p[23:16];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] v);
    logic [26:0] p;
    p = {16'b0, v} * 27'd13108;
    return p[23:16];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] v);
    logic [26:0] p;
    p = {16'b0, v} * 27'd9363;
    return p[23:16];
  endfunction

  function automatic logic [2:0][7:0] widen565(input logic [15:0] c);
    logic [2:0][7:0] o;
    o[0] = {c[15:11], c[15:13]};
    o[1] = {c[10:5], c[10:9]};
    o[2] = {c[4:0], c[4:2]};
    return o;
  endfunction

  function automatic palette_t make_palette(input logic [15:0] c0, input logic [15:0] c1,
                                            input logic [1:0] fmt);
    palette_t        p;
    logic [2:0][7:0] e0;
    logic [2:0][7:0] e1;
    logic            four;
    e0   = widen565(c0);
    e1   = widen565(c1);
    four = (fmt == FMT_BC2) || (fmt == FMT_BC3) || (c0 > c1);
    p.rgb[0] = e0;
    p.rgb[1] = e1;
    p.clear3 = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (four) begin
        p.rgb[2][k] = div3({1'b0, e0[k], 1'b0} + {2'b0, e1[k]});
        p.rgb[3][k] = div3({1'b0, e1[k], 1'b0} + {2'b0, e0[k]});
      end else begin
        p.rgb[2][k] = 8'(({1'b0, e0[k]} + {1'b0, e1[k]}) >> 1);
        p.rgb[3][k] = 8'd0;
      end
    end
    if (!four && (fmt == FMT_BC1_RGBA)) begin
      p.clear3 = 1'b1;
    end
    return p;
  endfunction

  function automatic logic [7:0][7:0] make_ramp(input logic [7:0] a0, input logic [7:0] a1);
    logic [7:0][7:0] r;
    logic [10:0]     s;
    r[0] = a0;
    r[1] = a1;
    if (a0 > a1) begin
      for (int i = 0; i < 6; i++) begin
        s = ({3'b0, a0} * 11'(6 - i)) + ({3'b0, a1} * 11'(i + 1));
        r[2 + i] = div7(s);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        s = ({3'b0, a0} * 11'(4 - i)) + ({3'b0, a1} * 11'(i + 1));
        r[2 + i] = div5(s);
      end
      r[6] = 8'd0;
      r[7] = 8'd255;
    end
    return r;
  endfunction

endpackage

[design/bcdec_front.sv]
// ----------------------------------------------------------------------------
// bcdec_front
// config registers, block position tracking and block classification
// ----------------------------------------------------------------------------
module bcdec_front
  import bcdec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_wr_t      cfg,
  input  logic         in_valid,
  output logic         in_ready,
  input  block_t       in_data,
  input  logic         q_full,
  output logic         push,
  output block_entry_t push_data
);

  logic [1:0]          format;
  logic [SIDE_W-1:0]   image_width;
  logic [SIDE_W-1:0]   image_height;
  logic [BLK_W-1:0]    block_column;
  logic [BLK_W-1:0]    block_row;

  logic [SIDE_W-1:0]   w_eff;
  logic [SIDE_W-1:0]   h_eff;
  logic [BCOUNT_W-1:0] bx_count;
  logic [BCOUNT_W-1:0] by_count;
  logic                last_col;
  logic                last_row;
  logic [COORD_W-1:0]  x0;
  logic [COORD_W-1:0]  y0;
  logic [SIDE_W-1:0]   diff_x;
  logic [SIDE_W-1:0]   diff_y;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (v > SIDE_W'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end
    return v;
  endfunction

  assign w_eff    = clamp_side(image_width);
  assign h_eff    = clamp_side(image_height);
  assign bx_count = BCOUNT_W'((w_eff + SIDE_W'(3)) >> 2);
  assign by_count = BCOUNT_W'((h_eff + SIDE_W'(3)) >> 2);
  assign last_col = ({1'b0, block_column} + BCOUNT_W'(1)) == bx_count;
  assign last_row = ({1'b0, block_row} + BCOUNT_W'(1)) == by_count;
  assign x0       = {block_column, 2'b00};
  assign y0       = {block_row, 2'b00};
  assign diff_x   = w_eff - {1'b0, x0};
  assign diff_y   = h_eff - {1'b0, y0};

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    push_data.pal        = make_palette(in_data.colour_half[15:0],
                                        in_data.colour_half[31:16], format);
    push_data.ramp       = make_ramp(in_data.alpha_half[7:0], in_data.alpha_half[15:8]);
    push_data.alpha_bits = in_data.alpha_half;
    push_data.sel        = in_data.colour_half[63:32];
    push_data.fmt        = format;
    push_data.x0         = x0;
    push_data.y0         = y0;
    push_data.last_px    = (diff_x >= SIDE_W'(4)) ? 2'd3 : 2'(diff_x - SIDE_W'(1));
    push_data.last_py    = (diff_y >= SIDE_W'(4)) ? 2'd3 : 2'(diff_y - SIDE_W'(1));
    push_data.last_block = last_col && last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format       <= FMT_BC1_RGB;
      image_width  <= SIDE_W'(MAX_SIDE);
      image_height <= SIDE_W'(MAX_SIDE);
      block_column <= '0;
      block_row    <= '0;
    end else if (cfg.en) begin
      unique case (cfg.index)
        REG_FORMAT: begin
          format <= cfg.data[1:0];
        end
        REG_IMAGE_WIDTH: begin
          image_width  <= cfg.data;
          block_column <= '0;
          block_row    <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg.data;
          block_column <= '0;
          block_row    <= '0;
        end
        default: begin
        end
      endcase
    end else if (push) begin
      if (last_col) begin
        block_column <= '0;
        block_row    <= last_row ? '0 : block_row + BLK_W'(1);
      end else begin
        block_column <= block_column + BLK_W'(1);
      end
    end
  end

endmodule

[design/bcdec_queue.sv]
// ----------------------------------------------------------------------------
// bcdec_queue
// short queue of classified blocks between front and back
// ----------------------------------------------------------------------------
module bcdec_queue
  import bcdec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  block_entry_t push_data,
  output logic         full,
  input  logic         pop,
  output block_entry_t head,
  output logic         head_valid
);

  block_entry_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[design/bcdec_back.sv]
// ----------------------------------------------------------------------------
// bcdec_back
// texel sequencer: while the output is not stalled, walks the in-image texels of the head block, one a cycle
// ----------------------------------------------------------------------------
module bcdec_back
  import bcdec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  block_entry_t head,
  input  logic         head_valid,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_ready,
  output texel_t       out_data
);

  logic [1:0]           px;
  logic [1:0]           py;
  logic [3:0]           t;
  logic                 advance;
  logic                 end_row;
  logic                 end_blk;
  logic [15:0][1:0]     sels;
  logic [15:0][3:0]     nibs;
  logic [15:0][2:0]     aidx;
  logic [1:0]           s;
  logic [7:0]           a;
  texel_t               texel;

  assign t       = {py, px};
  assign sels    = head.sel;
  assign nibs    = head.alpha_bits;
  assign aidx    = head.alpha_bits[63:16];
  assign s       = sels[t];
  assign advance = head_valid && (!out_valid || out_ready);
  assign end_row = px == head.last_px;
  assign end_blk = end_row && (py == head.last_py);
  assign pop     = advance && end_blk;

  always_comb begin
    case (head.fmt)
      FMT_BC2: a = {nibs[t], nibs[t]};
      FMT_BC3: a = head.ramp[aidx[t]];
      default: a = ((s == 2'd3) && head.pal.clear3) ? 8'd0 : 8'd255;
    endcase
    texel.pixel_x       = {head.x0[COORD_W-1:2], px};
    texel.pixel_y       = {head.y0[COORD_W-1:2], py};
    texel.red           = head.pal.rgb[s][0];
    texel.green         = head.pal.rgb[s][1];
    texel.blue          = head.pal.rgb[s][2];
    texel.alpha         = a;
    texel.last_of_block = end_blk;
    texel.last_of_image = end_blk && head.last_block;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= texel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      px        <= '0;
      py        <= '0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (end_row) begin
          px <= '0;
          py <= end_blk ? 2'd0 : py + 2'd1;
        end else begin
          px <= px + 2'd1;
        end
      end
    end
  end

endmodule

[design/bc1_bc2_bc3_block_decoder.sv]
// ----------------------------------------------------------------------------
// bc1_bc2_bc3_block_decoder
// decodes bc1/bc2/bc3 4x4 blocks in row-major block order to rgba8888 texels
// ----------------------------------------------------------------------------
// Each accepted block produces its in-image texels, row by row, from the
// back-end sequencer, which sets the sustained rate of one texel per cycle
// while out_ready is high: 16 texels for a full block, fewer (columns x rows)
// for blocks clipped at the right or bottom edge. The front end builds palette
// and alpha ramp in the accept cycle and takes a new block every cycle while
// the 2-entry block queue has room, so blocks stream without gaps; the first
// texel of a block passes through its queue entry and the output register.
// Configuration is written through wr_en/wr_index/wr_data; writing width or
// height restarts at block (0,0). There is no clearing pass after reset.
module bc1_bc2_bc3_block_decoder
  import bcdec_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  block_t               in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output texel_t               out_data,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [SIDE_W-1:0]    wr_data
);

  cfg_wr_t      cfg;
  logic         q_full;
  logic         push;
  block_entry_t push_data;
  logic         pop;
  block_entry_t head;
  logic         head_valid;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  bcdec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  bcdec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  bcdec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

[design/bcdec_checker.sv]
// ----------------------------------------------------------------------------
// bcdec_checker
// port-level checks of the block decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "bc1_bc2_bc3_block_decoder_defines.svh"

module bcdec_checker
  import bcdec_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   out_valid,
  input logic   out_ready,
  input texel_t out_data
);

  // stalled output transfer holds
  `BCDEC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")

  // end of image only on the end of a block
  `BCDEC_ASSERT_IMP(a_img_in_blk, out_valid && out_data.last_of_image, out_data.last_of_block, "last_of_image without last_of_block")

  // texels of one block come without gaps
  `BCDEC_ASSERT_NXT(a_blk_contig, out_valid && out_ready && !out_data.last_of_block, out_valid, "gap inside a block")

  // next texel of the same block is the next column or the start of the next row
  `BCDEC_ASSERT_NXT(a_blk_order, out_valid && out_ready && !out_data.last_of_block, (out_data.pixel_y == $past(out_data.pixel_y) && out_data.pixel_x == $past(out_data.pixel_x) + 12'd1) || (out_data.pixel_y == $past(out_data.pixel_y) + 12'd1 && out_data.pixel_x[1:0] == 2'b00), "texel order broken inside a block")

endmodule

bind bc1_bc2_bc3_block_decoder bcdec_checker u_checker (.*);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of the bc1/bc2/bc3 block decoder
// ----------------------------------------------------------------------------
// Blocks go in over a valid/ready channel and texels come back over another.
// A scoreboard class keeps its own copy of the format, the image size and the
// block position, decodes every accepted block into the texels it should
// produce, and checks each texel transfer against the oldest one still due.
// A short directed part covers palette modes, alpha modes, edge clipping and
// out-of-range geometry; random phases follow with different formats, image
// sizes and idling on both sides, plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
  import bcdec_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PRINT_CAP      = 50;

  class texel_scoreboard;
    logic [1:0]  fmt;
    int unsigned img_w;
    int unsigned img_h;
    int unsigned blk_col;
    int unsigned blk_row;
    texel_t      texels_due[$];
    int          errors;

    function new();
      fmt     = FMT_BC1_RGB;
      img_w   = MAX_SIDE;
      img_h   = MAX_SIDE;
      blk_col = 0;
      blk_row = 0;
      errors  = 0;
    endfunction

    function int unsigned clamp_side(int unsigned v);
      if (v == 0) return 1;
      if (v > MAX_SIDE) return MAX_SIDE;
      return v;
    endfunction

    function int pending();
      return texels_due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
      case (idx)
        REG_FORMAT: fmt = val[1:0];
        REG_IMAGE_WIDTH: begin
          img_w   = val;
          blk_col = 0;
          blk_row = 0;
        end
        REG_IMAGE_HEIGHT: begin
          img_h   = val;
          blk_col = 0;
          blk_row = 0;
        end
        default: ;
      endcase
    endfunction

    // decode one accepted block into the texels it should emit
    function void take_block(block_t b);
      int unsigned w, h, bx_n, by_n;
      int unsigned c0, c1, cw, r5, g6, b5, a0, a1;
      int unsigned x, y, t, s, a, nib, n;
      int unsigned pal[4][4];
      int unsigned ramp[8];
      bit          four;
      texel_t      tx;
      w    = clamp_side(img_w);
      h    = clamp_side(img_h);
      bx_n = (w + 3) / 4;
      by_n = (h + 3) / 4;
      if (blk_col >= bx_n) blk_col = 0;
      if (blk_row >= by_n) blk_row = 0;
      c0 = b.colour_half[15:0];
      c1 = b.colour_half[31:16];
      for (int e = 0; e < 2; e++) begin
        cw = (e == 0) ? c0 : c1;
        r5 = (cw >> 11) & 'h1f;
        g6 = (cw >> 5) & 'h3f;
        b5 = cw & 'h1f;
        pal[e][0] = ((r5 << 3) | (r5 >> 2)) & 255;
        pal[e][1] = ((g6 << 2) | (g6 >> 4)) & 255;
        pal[e][2] = ((b5 << 3) | (b5 >> 2)) & 255;
        pal[e][3] = 255;
      end
      four = (fmt == FMT_BC2) || (fmt == FMT_BC3) || (c0 > c1);
      for (int k = 0; k < 3; k++) begin
        if (four) begin
          pal[2][k] = (2 * pal[0][k] + pal[1][k]) / 3;
          pal[3][k] = (2 * pal[1][k] + pal[0][k]) / 3;
        end else begin
          pal[2][k] = (pal[0][k] + pal[1][k]) / 2;
          pal[3][k] = 0;
        end
      end
      pal[2][3] = 255;
      pal[3][3] = (!four && fmt == FMT_BC1_RGBA) ? 0 : 255;
      a0 = b.alpha_half[7:0];
      a1 = b.alpha_half[15:8];
      ramp[0] = a0;
      ramp[1] = a1;
      if (a0 > a1) begin
        for (int i = 0; i < 6; i++) ramp[2 + i] = ((6 - i) * a0 + (1 + i) * a1) / 7;
      end else begin
        for (int i = 0; i < 4; i++) ramp[2 + i] = ((4 - i) * a0 + (1 + i) * a1) / 5;
        ramp[6] = 0;
        ramp[7] = 255;
      end
      n = 0;
      for (int py = 0; py < 4; py++) begin
        y = blk_row * 4 + py;
        if (y >= h) break;
        for (int px = 0; px < 4; px++) begin
          x = blk_col * 4 + px;
          if (x >= w) break;
          t = py * 4 + px;
          s = b.colour_half[32 + 2 * t +: 2];
          a = pal[s][3];
          if (fmt == FMT_BC2) begin
            nib = b.alpha_half[4 * t +: 4];
            a   = (nib << 4) | nib;
          end else if (fmt == FMT_BC3) begin
            a = ramp[b.alpha_half[16 + 3 * t +: 3]];
          end
          tx.pixel_x       = COORD_W'(x);
          tx.pixel_y       = COORD_W'(y);
          tx.red           = 8'(pal[s][0]);
          tx.green         = 8'(pal[s][1]);
          tx.blue          = 8'(pal[s][2]);
          tx.alpha         = 8'(a);
          tx.last_of_block = 1'b0;
          tx.last_of_image = 1'b0;
          texels_due.push_back(tx);
          n++;
        end
      end
      if (n > 0) begin
        tx = texels_due.pop_back();
        tx.last_of_block = 1'b1;
        tx.last_of_image = (blk_col + 1 == bx_n) && (blk_row + 1 == by_n);
        texels_due.push_back(tx);
      end
      blk_col++;
      if (blk_col >= bx_n) begin
        blk_col = 0;
        blk_row++;
        if (blk_row >= by_n) blk_row = 0;
      end
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_texel(texel_t got);
      texel_t want;
      string  diff;
      diff = "";
      if (texels_due.size() == 0) begin
        report($sformatf("texel (%0d,%0d) with nothing due", got.pixel_x, got.pixel_y));
        return;
      end
      want = texels_due.pop_front();
      if (got.pixel_x !== want.pixel_x)
        diff = {diff, $sformatf(" x %0d/%0d", got.pixel_x, want.pixel_x)};
      if (got.pixel_y !== want.pixel_y)
        diff = {diff, $sformatf(" y %0d/%0d", got.pixel_y, want.pixel_y)};
      if (got.red !== want.red)
        diff = {diff, $sformatf(" red %h/%h", got.red, want.red)};
      if (got.green !== want.green)
        diff = {diff, $sformatf(" green %h/%h", got.green, want.green)};
      if (got.blue !== want.blue)
        diff = {diff, $sformatf(" blue %h/%h", got.blue, want.blue)};
      if (got.alpha !== want.alpha)
        diff = {diff, $sformatf(" alpha %h/%h", got.alpha, want.alpha)};
      if (got.last_of_block !== want.last_of_block)
        diff = {diff, $sformatf(" last_of_block %b/%b", got.last_of_block, want.last_of_block)};
      if (got.last_of_image !== want.last_of_image)
        diff = {diff, $sformatf(" last_of_image %b/%b", got.last_of_image, want.last_of_image)};
      if (diff != "")
        report($sformatf("texel (%0d,%0d) got/want:%s", want.pixel_x, want.pixel_y, diff));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  block_t               in_data;
  logic                 out_valid;
  logic                 out_ready;
  texel_t               out_data;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] wr_index;
  logic [SIDE_W-1:0]    wr_data;

  texel_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;
  bit hold_done      = 1'b0;
  int hold_count     = 0;
  int quiet_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bc1_bc2_bc3_block_decoder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  always @(posedge clk) begin
    if (!rst) begin
      if (wr_en) sb.write_reg(wr_index, wr_data);
      if (in_valid && in_ready) sb.take_block(in_data);
      if (out_valid && out_ready) sb.check_texel(out_data);
    end
  end

  // cycles with no transfer and no register write
  always @(posedge clk) begin
    if (rst || wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // texel receiver, with one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic block_t make_block(logic [63:0] alpha, logic [15:0] c0,
                                        logic [15:0] c1, logic [31:0] sel);
    return {alpha, sel, c1, c0};
  endfunction

  function automatic block_t random_block();
    block_t b;
    b.alpha_half  = {$urandom, $urandom};
    b.colour_half = {$urandom, $urandom};
    case ($urandom_range(3))
      0: b.colour_half[31:16] = b.colour_half[15:0];
      1: b.alpha_half[15:8] = b.alpha_half[7:0];
      default: ;
    endcase
    return b;
  endfunction

  task automatic send_block(input block_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [1:0] f, input int unsigned w, input int unsigned h,
                           input bit geom);
    wr_en    <= 1'b1;
    wr_index <= REG_FORMAT;
    wr_data  <= SIDE_W'(f);
    @(negedge clk);
    if (geom) begin
      wr_index <= REG_IMAGE_WIDTH;
      wr_data  <= SIDE_W'(w);
      @(negedge clk);
      wr_index <= REG_IMAGE_HEIGHT;
      wr_data  <= SIDE_W'(h);
      @(negedge clk);
    end
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk);
  endtask

  task automatic random_phase(input int p, input int n_items);
    int unsigned w, h;
    logic [1:0]  f;
    case (p % 4)
      0: set_idling(0, 0);
      1: set_idling(52, 0);
      2: set_idling(0, 52);
      default: set_idling(22, 22);
    endcase
    f = 2'((p + p / 4) % 4);
    w = $urandom_range(16, 1);
    h = $urandom_range(16, 1);
    if ($urandom_range(5) == 0) w = $urandom_range(1) ? 0 : 8191;
    if ($urandom_range(5) == 0) h = 0;
    // odd phases change only the format and carry on from the current block
    configure(f, w, h, (p % 2) == 0);
    repeat (n_items) send_block(random_block());
    drain();
  endtask

  initial begin
    sb       = new();
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    wr_en    = 1'b0;
    wr_index = REG_FORMAT;
    wr_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // bc1 rgb: four-colour, three-colour, equal endpoints
    configure(FMT_BC1_RGB, 8, 8, 1'b1);
    send_block(make_block(64'hffff_ffff_ffff_ffff, 16'hffff, 16'h0000, 32'he4e4_e4e4));
    send_block(make_block(64'h0, 16'h0000, 16'hffff, 32'he4e4_e4e4));
    send_block(make_block(64'h0123_4567_89ab_cdef, 16'h7bef, 16'h7bef, 32'hffff_ffff));
    send_block(make_block(64'hfedc_ba98_7654_3210, 16'hf800, 16'h07e0, 32'h1b1b_1b1b));
    drain();

    // bc1 punchthrough with right and bottom clipping
    configure(FMT_BC1_RGBA, 6, 5, 1'b1);
    send_block(make_block(64'h0, 16'h001f, 16'hf81f, 32'hffff_ffff));
    send_block(make_block(64'h0, 16'h8410, 16'h8410, 32'h39c6_b5ad));
    send_block(make_block(64'h0, 16'hffe0, 16'h001f, 32'he4e4_e4e4));
    send_block(make_block(64'h0, 16'h1234, 16'hfedc, 32'haaaa_aaaa));
    drain();

    // bc2 explicit alpha, palette always four-colour
    configure(FMT_BC2, 4, 4, 1'b1);
    send_block(make_block(64'hf0e1_d2c3_b4a5_9687, 16'h0841, 16'hf7be, 32'he4e4_e4e4));
    send_block(make_block(64'h0, 16'hffff, 16'hffff, 32'h0));
    send_block(make_block(64'hffff_ffff_ffff_ffff, 16'h5a5a, 16'ha5a5, 32'h6c6c_93c9));
    drain();

    // bc3 ramps: six-step, four-step with 0 and 255, equal endpoints
    configure(FMT_BC3, 3, 7, 1'b1);
    send_block(make_block(64'hfac6_88fa_c688_00ff, 16'hf81f, 16'h07e0, 32'he4e4_e4e4));
    send_block(make_block(64'hfac6_88fa_c688_ff00, 16'h0000, 16'hffff, 32'h4e4e_4e4e));
    send_block(make_block(64'hfac6_88fa_c688_8080, 16'h3333, 16'hcccc, 32'hb1b1_b1b1));
    send_block(make_block(64'h7777_1234_abcd_0f10, 16'h8000, 16'h0001, 32'h5555_5555));
    drain();

    // zero size is taken as one texel
    configure(FMT_BC1_RGB, 0, 0, 1'b1);
    send_block(make_block(64'h0, 16'hffff, 16'h0000, 32'h0000_0002));
    send_block(make_block(64'h0, 16'h0000, 16'hffff, 32'h0000_0003));
    drain();

    // write to the spare index has no effect, then oversized widths
    wr_en    <= 1'b1;
    wr_index <= REG_SPARE;
    wr_data  <= '1;
    @(negedge clk);
    configure(FMT_BC3, 5000, 1, 1'b1);
    send_block(make_block(64'h1234_5678_9abc_ff00, 16'hffff, 16'h0000, 32'hffff_0000));
    send_block(make_block(64'hffff_ffff_ffff_ffff, 16'h0000, 16'h0000, 32'h0));
    send_block(make_block(64'h0, 16'hffff, 16'hffff, 32'hffff_ffff));
    drain();
    configure(FMT_BC2, 8191, 8191, 1'b1);
    send_block(random_block());
    send_block(random_block());
    drain();

    for (int p = 0; p < 8; p++) random_phase(p, 8);

    // receiver holds off while blocks keep coming
    set_idling(0, 0);
    configure(FMT_BC3, 16, 16, 1'b1);
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    repeat (14) send_block(random_block());
    drain();

    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
